>>> hdl/fdn_pkg.sv
// Shared types, codes and fixed-point helpers for the sixteen-line FDN reverb.
// No dependencies; used by fdn_shelf and fdn_reverb_sixteen_line_core.
package fdn_pkg;

   localparam int LINES     = 16;
   localparam int LINE_BITS = 4;
   localparam int MIX_STEPS = 4;

   typedef logic signed [31:0] word_type;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_LOAD   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WET_MIX       = 2'd0,
      CSR_OUTPUT_GAIN   = 2'd1,
      CSR_CURRENT_GAIN  = 2'd2,
      CSR_PREVIOUS_GAIN = 2'd3
   } csr_type;

   typedef struct packed {
      logic [16:0]        wet_mix;
      logic [31:0]        output_gain;
      logic [30:0]        current_gain;
      logic signed [31:0] previous_gain;
   } cfg_type;

   // saturate a 33-bit sum to 32 bits
   function automatic word_type sat32(input logic signed [32:0] x);
      word_type r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Q.16 product: round half up, shift, saturate to 32 bits
   function automatic word_type rnd_q16(input logic signed [65:0] p);
      logic signed [65:0] t;
      word_type           r;
      t = (p + 66'sd32768) >>> 16;
      if ((t[65:31] == '0) || (t[65:31] == '1)) begin
         r = t[31:0];
      end else begin
         r = t[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

>>> hdl/fdn_shelf.sv
// One-zero shelf, output gain and wet/dry mix for one channel; six register stages.
// Depends on fdn_pkg. Inputs are held stable by the core while the result settles.
module fdn_shelf #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  fdn_pkg::cfg_type              cfg,
   input  fdn_pkg::word_type             cur,
   input  fdn_pkg::word_type             prev,
   input  logic signed [SAMPLE_BITS-1:0] dry,
   output logic signed [SAMPLE_BITS-1:0] mix
);

   logic signed [63:0]  pc_ff, ph_ff;
   fdn_pkg::word_type   s_ff;
   logic signed [64:0]  pf_ff;
   logic signed [32:0]  diff_ff;
   logic signed [50:0]  pm_ff;
   logic signed [SAMPLE_BITS-1:0] mix_ff;

   logic [16:0]         wet;
   logic signed [50:0]  pm_r;
   logic signed [35:0]  sum;
   logic signed [35:0]  hi_lim, lo_lim;

   always_comb begin
      wet    = (cfg.wet_mix > 17'd65536) ? 17'd65536 : cfg.wet_mix;
      pm_r   = (pm_ff + 51'sd32768) >>> 16;
      sum    = 36'(dry) + 36'(pm_r);
      hi_lim = (36'sd1 <<< (SAMPLE_BITS - 1)) - 36'sd1;
      lo_lim = -hi_lim - 36'sd1;
   end

   always_ff @(posedge clock) begin
      pc_ff   <= $signed(cur) * $signed({1'b0, cfg.current_gain});
      ph_ff   <= $signed(prev) * $signed(cfg.previous_gain);
      s_ff    <= fdn_pkg::sat32(33'(fdn_pkg::rnd_q16(66'(pc_ff)))
                              + 33'(fdn_pkg::rnd_q16(66'(ph_ff))));
      pf_ff   <= $signed(s_ff) * $signed({1'b0, cfg.output_gain});
      diff_ff <= 33'(fdn_pkg::rnd_q16(66'(pf_ff))) - 33'(dry);
      pm_ff   <= $signed({1'b0, wet}) * diff_ff;
      if (sum > hi_lim) begin
         mix_ff <= hi_lim[SAMPLE_BITS-1:0];
      end else if (sum < lo_lim) begin
         mix_ff <= lo_lim[SAMPLE_BITS-1:0];
      end else begin
         mix_ff <= sum[SAMPLE_BITS-1:0];
      end
   end

   assign mix = mix_ff;

endmodule

>>> hdl/fdn_reverb_sixteen_line_core.sv
// Sixteen-line FDN reverb: ring memory, line filters, Hadamard mixer, control.
// Depends on fdn_pkg and fdn_shelf. Sample beat, accept to result: 16 ring reads, a drain
// through the memory and product registers, 4 butterfly stages, 16 ring writes, then the
// result is presented; the next beat can be taken in the cycle after. Load and unused beats
// keep the core idle. A result stalled in the output register holds the next sample in its
// last step. After reset or a clear beat, a clearing pass zeroes the ring with req_stall high.
module fdn_reverb_sixteen_line_core #(
   parameter int LINE_DEPTH  = 8192,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          req_mono,
   input  logic [3:0]                    req_line_index,
   input  logic [13:0]                   req_line_delay,
   input  logic [15:0]                   req_line_feedback,
   input  logic [15:0]                   req_line_damping,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_data
);

   localparam int PW        = $clog2(LINE_DEPTH);
   localparam int MEM_DEPTH = fdn_pkg::LINES * LINE_DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int DW        = (PW + 1 > 14) ? PW + 1 : 14;
   localparam int LB        = fdn_pkg::LINE_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_MIX, ST_WRITE, ST_DONE
   } state_type;

   state_type           state_ff;
   logic [AW-1:0]       clr_cnt_ff;
   logic [PW-1:0]       wp_ff;
   logic [LB-1:0]       rd_cnt_ff, a_line_ff, b_line_ff, c_line_ff, wr_cnt_ff;
   logic                issuing_ff, a_vld_ff, b_vld_ff, c_vld_ff;
   logic [1:0]          mix_cnt_ff;
   logic                rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;
   fdn_pkg::word_type   prev_left_ff, prev_right_ff;
   fdn_pkg::cfg_type    cfg_ff;

   logic [13:0]         delay_ff [fdn_pkg::LINES];
   logic [15:0]         feedback_ff [fdn_pkg::LINES];
   logic [15:0]         damping_ff [fdn_pkg::LINES];
   fdn_pkg::word_type   hist_ff [fdn_pkg::LINES];
   fdn_pkg::word_type   v_ff [fdn_pkg::LINES];
   fdn_pkg::word_type   had [fdn_pkg::LINES];

   logic [31:0]         ring_mem [MEM_DEPTH];
   logic [31:0]         mem_q_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa, mem_ra;
   logic [31:0]         mem_wd;

   logic [PW-1:0]       rdpos_ff, rdpos_in;
   logic signed [48:0]  prod_fb_ff, prod_dm_ff;
   fdn_pkg::word_type   v_d;

   logic signed [SAMPLE_BITS-1:0] dry_l_ff, dry_r_ff;
   fdn_pkg::word_type   tank_ff;
   logic signed [SAMPLE_BITS:0]   lr_sum;
   logic signed [SAMPLE_BITS-1:0] shelf_l, shelf_r;

   logic                req_accept;
   logic                out_free;
   logic [DW-1:0]       dly, dcl, wpx;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // read position for the line being issued
   always_comb begin
      dly = DW'(delay_ff[rd_cnt_ff]);
      if (dly == '0) begin
         dcl = DW'(1);
      end else if (dly > DW'(LINE_DEPTH)) begin
         dcl = DW'(LINE_DEPTH);
      end else begin
         dcl = dly;
      end
      wpx = DW'(wp_ff);
      if (wpx >= dcl) begin
         rdpos_in = PW'(wpx - dcl);
      end else begin
         rdpos_in = PW'(wpx + DW'(LINE_DEPTH) - dcl);
      end
   end

   assign v_d = fdn_pkg::sat32(33'(fdn_pkg::rnd_q16(66'(prod_fb_ff)))
                             + 33'(fdn_pkg::rnd_q16(66'(prod_dm_ff))));

   // one butterfly stage per cycle, stride 1, 2, 4, 8
   always_comb begin
      for (int j = 0; j < fdn_pkg::LINES; j++) begin
         had[j] = v_ff[j];
      end
      for (int k = 0; k < fdn_pkg::MIX_STEPS; k++) begin
         if (mix_cnt_ff == 2'(k)) begin
            for (int j = 0; j < fdn_pkg::LINES; j++) begin
               if ((j & (1 << k)) == 0) begin
                  had[j] = fdn_pkg::sat32(33'(v_ff[j]) + 33'(v_ff[j ^ (1 << k)]));
               end else begin
                  had[j] = fdn_pkg::sat32(33'(v_ff[j ^ (1 << k)]) - 33'(v_ff[j]));
               end
            end
         end
      end
   end

   // ring memory ports
   always_comb begin
      mem_ra = AW'(a_line_ff) * AW'(LINE_DEPTH) + AW'(rdpos_ff);
      mem_we = 1'b0;
      mem_wa = clr_cnt_ff;
      mem_wd = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_WRITE) begin
         mem_we = 1'b1;
         mem_wa = AW'(wr_cnt_ff) * AW'(LINE_DEPTH) + AW'(wp_ff);
         mem_wd = fdn_pkg::sat32(33'(tank_ff) + 33'(v_ff[wr_cnt_ff]));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= ring_mem[mem_ra];
   end

   // line filter datapath
   always_ff @(posedge clock) begin
      rdpos_ff   <= rdpos_in;
      prod_fb_ff <= $signed(mem_q_ff) * $signed({1'b0, feedback_ff[b_line_ff]});
      prod_dm_ff <= $signed(hist_ff[b_line_ff]) * $signed({1'b0, damping_ff[b_line_ff]});
      if (c_vld_ff) begin
         v_ff[c_line_ff] <= v_d;
      end else if (state_ff == ST_MIX) begin
         v_ff <= had;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < fdn_pkg::LINES; j++) begin
            hist_ff[j] <= '0;
         end
      end else if (req_accept && req_op == fdn_pkg::OP_CLEAR) begin
         for (int j = 0; j < fdn_pkg::LINES; j++) begin
            hist_ff[j] <= '0;
         end
      end else if (c_vld_ff) begin
         hist_ff[c_line_ff] <= v_d;
      end
   end

   // line coefficients and dry samples
   always_comb begin
      lr_sum = (SAMPLE_BITS+1)'(req_left_sample) + (SAMPLE_BITS+1)'(req_right_sample);
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_op == fdn_pkg::OP_LOAD) begin
         delay_ff[req_line_index]    <= req_line_delay;
         feedback_ff[req_line_index] <= req_line_feedback;
         damping_ff[req_line_index]  <= req_line_damping;
      end
      if (req_accept && req_op == fdn_pkg::OP_SAMPLE) begin
         dry_l_ff <= req_left_sample;
         dry_r_ff <= req_mono ? req_left_sample : req_right_sample;
         tank_ff  <= req_mono ? 32'(req_left_sample)
                              : 32'($signed(lr_sum[SAMPLE_BITS:1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wet_mix       <= 17'd0;
         cfg_ff.output_gain   <= 32'd65536;
         cfg_ff.current_gain  <= 31'd98304;
         cfg_ff.previous_gain <= -32'sd32768;
      end else if (csr_write) begin
         unique case (fdn_pkg::csr_type'(csr_index))
            fdn_pkg::CSR_WET_MIX:       cfg_ff.wet_mix       <= csr_data[16:0];
            fdn_pkg::CSR_OUTPUT_GAIN:   cfg_ff.output_gain   <= csr_data;
            fdn_pkg::CSR_CURRENT_GAIN:  cfg_ff.current_gain  <= csr_data[30:0];
            fdn_pkg::CSR_PREVIOUS_GAIN: cfg_ff.previous_gain <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   fdn_shelf #(.SAMPLE_BITS(SAMPLE_BITS)) u_shelf_l (
      .clock(clock), .cfg(cfg_ff), .cur(v_ff[1]), .prev(prev_left_ff),
      .dry(dry_l_ff), .mix(shelf_l)
   );

   fdn_shelf #(.SAMPLE_BITS(SAMPLE_BITS)) u_shelf_r (
      .clock(clock), .cfg(cfg_ff), .cur(v_ff[2]), .prev(prev_right_ff),
      .dry(dry_r_ff), .mix(shelf_r)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         wp_ff         <= '0;
         rd_cnt_ff     <= '0;
         wr_cnt_ff     <= '0;
         a_line_ff     <= '0;
         b_line_ff     <= '0;
         c_line_ff     <= '0;
         issuing_ff    <= 1'b0;
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         c_vld_ff      <= 1'b0;
         mix_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
      end else begin
         a_vld_ff  <= issuing_ff;
         a_line_ff <= rd_cnt_ff;
         b_vld_ff  <= a_vld_ff;
         b_line_ff <= a_line_ff;
         c_vld_ff  <= b_vld_ff;
         c_line_ff <= b_line_ff;
         if (issuing_ff) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == LB'(fdn_pkg::LINES - 1)) begin
               issuing_ff <= 1'b0;
            end
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(MEM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  unique case (req_op)
                     fdn_pkg::OP_SAMPLE: begin
                        state_ff   <= ST_READ;
                        rd_cnt_ff  <= '0;
                        issuing_ff <= 1'b1;
                     end
                     fdn_pkg::OP_CLEAR: begin
                        state_ff      <= ST_CLEAR;
                        clr_cnt_ff    <= '0;
                        wp_ff         <= '0;
                        prev_left_ff  <= '0;
                        prev_right_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_READ: begin
               if (c_vld_ff && c_line_ff == LB'(fdn_pkg::LINES - 1)) begin
                  state_ff   <= ST_MIX;
                  mix_cnt_ff <= '0;
               end
            end
            ST_MIX: begin
               mix_cnt_ff <= mix_cnt_ff + 1'b1;
               if (mix_cnt_ff == 2'(fdn_pkg::MIX_STEPS - 1)) begin
                  state_ff  <= ST_WRITE;
                  wr_cnt_ff <= '0;
               end
            end
            ST_WRITE: begin
               wr_cnt_ff <= wr_cnt_ff + 1'b1;
               if (wr_cnt_ff == LB'(fdn_pkg::LINES - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_left_ff   <= shelf_l;
                  rsp_right_ff  <= shelf_r;
                  prev_left_ff  <= v_ff[1];
                  prev_right_ff <= v_ff[2];
                  wp_ff         <= (wp_ff == PW'(LINE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;

endmodule

>>> tb/tb_fdn_reverb_sixteen_line_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for fdn_reverb_sixteen_line_core: directed table with expected values,
// then random beats checked against a fixed-point reverb predictor. Depends on fdn_pkg and the RTL.
module tb_fdn_reverb_sixteen_line_core;

   localparam int DEPTH = 8192;
   localparam int NLINE = 16;

   typedef struct {
      fdn_pkg::op_type op;
      int          left;
      int          right;
      bit          mono;
      int          idx;
      int          dly;
      int          fb;
      int          damp;
      bit          typed;
      int          exp_l;
      int          exp_r;
   } beat_type;

   typedef struct {
      logic signed [23:0] l;
      logic signed [23:0] r;
   } frame_type;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   logic [1:0]          req_op = fdn_pkg::OP_SAMPLE;
   logic signed [23:0]  req_left_sample = 0;
   logic signed [23:0]  req_right_sample = 0;
   logic                req_mono = 0;
   logic [3:0]          req_line_index = 0;
   logic [13:0]         req_line_delay = 0;
   logic [15:0]         req_line_feedback = 0;
   logic [15:0]         req_line_damping = 0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic signed [23:0]  rsp_out_left;
   logic signed [23:0]  rsp_out_right;
   logic                csr_write = 0;
   logic [1:0]          csr_index = fdn_pkg::CSR_WET_MIX;
   logic [31:0]         csr_data = 0;

   fdn_reverb_sixteen_line_core u_top (.*);

   always #5 clock = ~clock;

   // predictor state
   int          ring [NLINE*DEPTH];
   int          wpos;
   int          hist [NLINE];
   int          prev_l, prev_r;
   int          dly_tab [NLINE];
   int          fb_tab [NLINE];
   int          damp_tab [NLINE];
   longint      wet, ogain, cgain, pgain;

   frame_type   pending_frames[$];
   beat_type    table_rows[$];
   int          errors = 0;
   bit          calm = 0;
   int          seen = 0;

   function automatic longint sat_w(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic int mulq(longint a, longint b);
      return int'(sat_w((a * b + 32768) >>> 16, 32));
   endfunction

   function automatic longint shelf(int cur, int prv, longint dry);
      int     c, h, f;
      longint w;
      c = mulq(cur, cgain);
      h = mulq(prv, pgain);
      f = mulq(sat_w(longint'(c) + h, 32), ogain);
      w = wet > 65536 ? 65536 : wet;
      return sat_w(dry + ((w * (longint'(f) - dry) + 32768) >>> 16), 24);
   endfunction

   task automatic clear_tank();
      foreach (ring[i]) ring[i] = 0;
      foreach (hist[i]) hist[i] = 0;
      wpos = 0;
      prev_l = 0;
      prev_r = 0;
   endtask

   task automatic reverb_frame(input longint l, input longint r_in, input bit mono,
                               output frame_type res);
      int     v [NLINE];
      int     d, rd, stride, base, k;
      longint a, b, r, tank;
      for (int i = 0; i < NLINE; i++) begin
         d = dly_tab[i];
         if (d < 1) d = 1;
         if (d > DEPTH) d = DEPTH;
         rd = (wpos + DEPTH - d) % DEPTH;
         v[i] = int'(sat_w(longint'(mulq(ring[i*DEPTH + rd], fb_tab[i]))
                           + mulq(hist[i], damp_tab[i]), 32));
         hist[i] = v[i];
      end
      for (stride = 1; stride < NLINE; stride *= 2)
         for (base = 0; base < NLINE; base += 2 * stride)
            for (k = 0; k < stride; k++) begin
               a = v[base + k];
               b = v[base + k + stride];
               v[base + k] = int'(sat_w(a + b, 32));
               v[base + k + stride] = int'(sat_w(a - b, 32));
            end
      r = mono ? l : r_in;
      res.l = 24'(shelf(v[1], prev_l, l));
      prev_l = v[1];
      res.r = 24'(shelf(v[2], prev_r, r));
      prev_r = v[2];
      tank = mono ? l : ((l + r) >>> 1);
      for (int i = 0; i < NLINE; i++) ring[i*DEPTH + wpos] = int'(sat_w(tank + v[i], 32));
      wpos = (wpos + 1) % DEPTH;
   endtask

   task automatic csr_put(input fdn_pkg::csr_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_write = 1;
      csr_index = idx;
      csr_data = value;
      case (idx)
         fdn_pkg::CSR_WET_MIX:       wet = value & 32'h1ffff;
         fdn_pkg::CSR_OUTPUT_GAIN:   ogain = value;
         fdn_pkg::CSR_CURRENT_GAIN:  cgain = value & 32'h7fffffff;
         fdn_pkg::CSR_PREVIOUS_GAIN: pgain = longint'(signed'(value));
      endcase
      @(negedge clock);
      csr_write = 0;
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send(input beat_type bt);
      frame_type fr;
      while (!calm && $urandom_range(99) < 17) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_op = bt.op;
      req_left_sample = bt.left[23:0];
      req_right_sample = bt.right[23:0];
      req_mono = bt.mono;
      req_line_index = bt.idx[3:0];
      req_line_delay = bt.dly[13:0];
      req_line_feedback = bt.fb[15:0];
      req_line_damping = bt.damp[15:0];
      do @(posedge clock); while (req_stall);
      case (bt.op)
         fdn_pkg::OP_LOAD: begin
            dly_tab[bt.idx[3:0]] = bt.dly & 16'h3fff;
            fb_tab[bt.idx[3:0]] = bt.fb & 16'hffff;
            damp_tab[bt.idx[3:0]] = bt.damp & 16'hffff;
         end
         fdn_pkg::OP_CLEAR: clear_tank();
         fdn_pkg::OP_SAMPLE: begin
            reverb_frame(longint'(signed'(bt.left[23:0])), longint'(signed'(bt.right[23:0])),
                         bt.mono, fr);
            if (bt.typed) begin
               fr.l = bt.exp_l[23:0];
               fr.r = bt.exp_r[23:0];
            end
            pending_frames.push_back(fr);
         end
         default: ;
      endcase
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic beat_type rand_beat(input int clear_ok);
      beat_type bt;
      int       p;
      p = $urandom_range(99);
      bt.op = p < 82 ? fdn_pkg::OP_SAMPLE
                     : (p < 94 ? fdn_pkg::OP_LOAD : fdn_pkg::OP_UNUSED);
      if (clear_ok) bt.op = fdn_pkg::OP_CLEAR;
      bt.left = int'($urandom);
      bt.right = int'($urandom);
      bt.mono = $urandom_range(3) == 0;
      bt.idx = $urandom_range(15);
      bt.dly = $urandom_range(3) == 0 ? $urandom_range(16383) : $urandom_range(600);
      bt.fb = $urandom_range(65535);
      bt.damp = $urandom_range(65535);
      bt.typed = 0;
      return bt;
   endfunction

   function automatic beat_type row(fdn_pkg::op_type op, int l, int r, bit m, int i, int d,
                                    int f, int dm, bit typed, int el, int er);
      beat_type bt;
      bt = '{op, l, r, m, i, d, f, dm, typed, el, er};
      return bt;
   endfunction

   // receiver: random stalls, one long hold-off after a hundred frames
   initial begin
      int hold;
      bit held;
      frame_type e;
      hold = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (pending_frames.size() == 0) begin
               $error("unexpected beat: out_left %0d out_right %0d", rsp_out_left, rsp_out_right);
               errors++;
            end else begin
               e = pending_frames.pop_front();
               if (rsp_out_left !== e.l) begin
                  $error("out_left expected %0d actual %0d", e.l, rsp_out_left);
                  errors++;
               end
               if (rsp_out_right !== e.r) begin
                  $error("out_right expected %0d actual %0d", e.r, rsp_out_right);
                  errors++;
               end
            end
            if (seen == 100 && !held) begin
               held = 1;
               hold = 600;
            end
         end
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 17;
         end
      end
   end

   initial begin
      #30_000_000;
      $display("fdn_reverb_sixteen_line_core verification failed");
      $finish;
   end

   initial begin
      beat_type bt;
      logic [31:0] cfg [5][4];
      clear_tank();
      foreach (dly_tab[i]) begin
         dly_tab[i] = 0;
         fb_tab[i] = 0;
         damp_tab[i] = 0;
      end
      wet = 0;
      ogain = 65536;
      cgain = 98304;
      pgain = -32768;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // lines must all carry coefficients before the first sample beat
      for (int i = 0; i < NLINE; i++)
         send(row(fdn_pkg::OP_LOAD, 0, 0, 0, i, i * 37 + 1, $urandom_range(65535),
                  $urandom_range(65535), 0, 0, 0));
      // wet mix is zero after reset, so every output equals the dry input
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, 8388607, -8388608, 0, 0, 0, 0, 0, 1,
                               8388607, -8388608));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, -8388608, 8388607, 0, 0, 0, 0, 0, 1,
                               -8388608, 8388607));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, -8388608, 123, 1, 0, 0, 0, 0, 1,
                               -8388608, -8388608));
      table_rows.push_back(row(fdn_pkg::OP_LOAD, 0, 0, 0, 0, 0, 65535, 65535, 0, 0, 0));
      table_rows.push_back(row(fdn_pkg::OP_LOAD, 0, 0, 0, 15, 16383, 0, 0, 0, 0, 0));
      table_rows.push_back(row(fdn_pkg::OP_LOAD, 0, 0, 0, 7, 8192, 65535, 0, 0, 0, 0));
      table_rows.push_back(row(fdn_pkg::OP_UNUSED, -1, -1, 1, 15, 16383, 65535, 65535,
                               0, 0, 0));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, 5, -7, 0, 0, 0, 0, 0, 1, 5, -7));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, 8388607, 8388607, 0, 0, 0, 0, 0, 1,
                               8388607, 8388607));
      table_rows.push_back(row(fdn_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, -1, -1, 0, 0, 0, 0, 0, 1, -1, -1));
      table_rows.push_back(row(fdn_pkg::OP_SAMPLE, 8388607, 8388607, 1, 0, 0, 0, 0, 1,
                               8388607, 8388607));
      foreach (table_rows[i]) send(table_rows[i]);

      cfg[0] = '{32'd65536, 32'd65536, 32'd98304, 32'hffff8000};
      cfg[1] = '{32'd32768, 32'd16384, 32'd65536, 32'hffffc000};
      cfg[2] = '{32'h1ffff, 32'hffffffff, 32'h7fffffff, 32'h80000000};
      cfg[3] = '{32'd0, 32'd0, 32'd0, 32'd0};
      cfg[4] = '{32'd49152, 32'd4096, 32'd70000, 32'hfffe0000};
      for (int ph = 0; ph < 5; ph++) begin
         wait (pending_frames.size() == 0);
         for (int c = 0; c < 4; c++) csr_put(fdn_pkg::csr_type'(c), cfg[ph][c]);
         @(negedge clock);
         calm = ph == 1;
         for (int n = 0; n < 200; n++) begin
            bt = rand_beat(ph == 3 && n == 20);
            if (n == 199) bt.op = fdn_pkg::OP_SAMPLE;
            send(bt);
         end
         calm = 0;
      end
      wait (pending_frames.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_frames.size() == 0) begin
         $display("fdn_reverb_sixteen_line_core verification clean");
      end else begin
         $display("fdn_reverb_sixteen_line_core verification failed");
      end
      $finish;
   end

endmodule
